// ===== src/multilevel_ready_queue_macros.svh =====
// assertion macros shared by the ready queue rtl
`ifndef MULTILEVEL_READY_QUEUE_MACROS_SVH
`define MULTILEVEL_READY_QUEUE_MACROS_SVH

// property checked on every rising edge of clk, off while arst_n is low
`define MRQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same-cycle implication
`define MRQ_ASSERT_IMPLY(lbl, ante, cons, msg) \
	`MRQ_ASSERT(lbl, (ante) |-> (cons), msg)

// next-cycle implication
`define MRQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	`MRQ_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ===== src/mrq_pkg.sv =====
// constants, codes and shared types of the ready queue
`timescale 1ns / 1ps
package mrq_pkg;
	localparam int LEVELS   = 4;
	localparam int CAPACITY = 16;
	localparam int ID_BITS  = 8;

	localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int SLOT_W    = $clog2(CAPACITY);
	localparam int ADDR_W    = LVL_W + SLOT_W;
	localparam int MEM_DEPTH = (1 << ADDR_W);
	localparam int CNT_W     = $clog2(CAPACITY + 1);

	localparam int TOT_W    = 5;
	localparam int MODE_W   = 2;
	localparam int ACT_W    = 2;
	localparam int PRIO_W   = 3;
	localparam int PID_W    = 8;
	localparam int RND_W    = 16;
	localparam int RND_CNT_W = $clog2(RND_W);
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;

	typedef enum logic [ACT_W-1:0] {
		ACT_INSERT = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_SELECT = 2'd2
	} action_t;

	localparam logic [MODE_W-1:0] MODE_NONE   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_STRICT = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RANDOM = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_MODE      = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_TOTAL = 1'd1;

	localparam logic [MODE_W-1:0] MODE_RST      = MODE_STRICT;
	localparam logic [TOT_W-1:0]  MAX_TOTAL_RST = 5'd16;

	typedef struct packed {
		logic               we;
		logic [ADDR_W-1:0]  addr;
		logic [ID_BITS-1:0] data;
	} mem_wr_t;

	typedef struct packed {
		logic             valid;
		logic [RND_W-1:0] dividend;
		logic [CNT_W-1:0] divisor;
	} mod_req_t;

	typedef struct packed {
		logic             done;
		logic [CNT_W-1:0] rem;
	} mod_rsp_t;
endpackage

// ===== src/mrq_mem.sv =====
// entry store: one write port, one registered read port
`timescale 1ns / 1ps
module mrq_mem
	import mrq_pkg::*;
(
	input  logic               clk,
	input  mem_wr_t            wr,
	input  logic [ADDR_W-1:0]  raddr,
	output logic [ID_BITS-1:0] rdata
);
	logic [ID_BITS-1:0] mem [MEM_DEPTH];
	logic [ID_BITS-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ===== src/mrq_mod.sv =====
// serial remainder unit, one dividend bit per cycle
`timescale 1ns / 1ps
module mrq_mod
	import mrq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  mod_req_t req,
	output mod_rsp_t rsp
);
	logic                 busy_q;
	logic                 done_q;
	logic [RND_CNT_W-1:0] step_q;
	logic [RND_W-1:0]     quo_q;
	logic [CNT_W-1:0]     div_q;
	logic [CNT_W-1:0]     rem_q;
	logic [CNT_W:0]       trial;

	assign trial = {rem_q, quo_q[RND_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
			quo_q  <= '0;
			div_q  <= '0;
			rem_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				// restoring step: shift in next bit, subtract if it fits
				if (trial >= {1'b0, div_q}) begin
					rem_q <= CNT_W'(trial - {1'b0, div_q});
				end else begin
					rem_q <= trial[CNT_W-1:0];
				end
				quo_q  <= {quo_q[RND_W-2:0], 1'b0};
				step_q <= step_q + 1'b1;
				if (step_q == RND_CNT_W'(RND_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (req.valid) begin
				busy_q <= 1'b1;
				step_q <= '0;
				quo_q  <= req.dividend;
				div_q  <= req.divisor;
				rem_q  <= '0;
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;
endmodule

// ===== src/multilevel_ready_queue.sv =====
// ready queue top level: sequencer, level counters and configuration
// insert, unknown action and select with nothing to pick or in mode none finish straight
// from idle; strict select reads the head slot; random select first waits in S_SEL_MOD for
// the serial remainder, one bit of random_value per cycle; remove compares entries level by
// level, then closes the gap slot by slot; one word at a time, busy high until done
// reset: levels empty, mode strict head, limit 16; entry store is not cleared; done cannot stall
`timescale 1ns / 1ps
`include "multilevel_ready_queue_macros.svh"
module multilevel_ready_queue
	import mrq_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// command side
	input  logic                  start,
	output logic                  busy,
	input  logic [ACT_W-1:0]      action,
	input  logic [PID_W-1:0]      process_id,
	input  logic [PRIO_W-1:0]     priority_req,
	input  logic [RND_W-1:0]      random_value,
	// result side, one word per done strobe
	output logic                  done,
	output logic                  success,
	output logic                  found,
	output logic [PID_W-1:0]      selected_id,
	// configuration writes
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);
	typedef enum logic [2:0] {
		S_IDLE,
		S_RM_LVL,   // pick next slot to compare or move to next level
		S_RM_CMP,   // compare read word against id
		S_SH_RD,    // read the word behind the gap
		S_SH_WR,    // write it one slot forward
		S_SEL_MOD,  // wait for random index
		S_SEL_RD,   // read the chosen slot
		S_SEL_OUT   // present the chosen id
	} state_t;

	state_t              state_q;
	logic [LVL_W-1:0]    lvl_q;
	logic [CNT_W-1:0]    idx_q;
	logic [SLOT_W-1:0]   sel_slot_q;
	logic [ID_BITS-1:0]  id_q;
	logic [CNT_W-1:0]    cnt_q [LEVELS];
	logic [TOT_W-1:0]    total_q;
	logic [MODE_W-1:0]   mode_q;
	logic [TOT_W-1:0]    max_q;
	logic                done_q;
	logic                success_q;
	logic                found_q;
	logic [PID_W-1:0]    sel_id_q;

	action_t             act;
	logic                accept;
	logic [ID_BITS-1:0]  in_id;
	logic                ins_prio_hi;
	logic [LVL_W-1:0]    ins_lvl;
	logic                ins_room;
	logic                top_any;
	logic [LVL_W-1:0]    top_lvl;
	logic                sel_mode_ok;
	logic [TOT_W-1:0]    cnt_sum;
	mem_wr_t             mem_wr;
	logic [ADDR_W-1:0]   mem_raddr;
	logic [ID_BITS-1:0]  mem_rdata;
	mod_req_t            mod_req;
	mod_rsp_t            mod_rsp;

	assign act    = action_t'(action);
	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);
	assign in_id  = ID_BITS'(process_id);

	// insert checks: levels past the last one are dropped but reported ok
	assign ins_prio_hi = (32'(priority_req) >= LEVELS);
	assign ins_lvl     = priority_req[LVL_W-1:0];
	assign ins_room    = (total_q < max_q) && (32'(cnt_q[ins_lvl]) < CAPACITY);

	assign sel_mode_ok = (mode_q == MODE_STRICT) || (mode_q == MODE_RANDOM);

	// lowest non-empty level
	always_comb begin
		top_any = 1'b0;
		top_lvl = '0;
		for (int lv = LEVELS - 1; lv >= 0; lv--) begin
			if (cnt_q[lv] != '0) begin
				top_any = 1'b1;
				top_lvl = LVL_W'(lv);
			end
		end
	end

	always_comb begin
		cnt_sum = '0;
		for (int lv = 0; lv < LEVELS; lv++) begin
			cnt_sum = cnt_sum + TOT_W'(cnt_q[lv]);
		end
	end

	// store write: tail append on insert, one step of gap closing on remove
	always_comb begin
		mem_wr.we   = 1'b0;
		mem_wr.addr = {ins_lvl, cnt_q[ins_lvl][SLOT_W-1:0]};
		mem_wr.data = in_id;
		if (state_q == S_SH_WR) begin
			mem_wr.we   = 1'b1;
			mem_wr.addr = {lvl_q, idx_q[SLOT_W-1:0]};
			mem_wr.data = mem_rdata;
		end else if (accept && act == ACT_INSERT && !ins_prio_hi && ins_room) begin
			mem_wr.we = 1'b1;
		end
	end

	always_comb begin
		case (state_q)
			S_SH_RD:  mem_raddr = {lvl_q, SLOT_W'(idx_q + 1'b1)};
			S_SEL_RD: mem_raddr = {lvl_q, sel_slot_q};
			default:  mem_raddr = {lvl_q, idx_q[SLOT_W-1:0]};
		endcase
	end

	// random index is random_value mod count of the lowest non-empty level
	assign mod_req.valid    = accept && act == ACT_SELECT && top_any && mode_q == MODE_RANDOM;
	assign mod_req.dividend = random_value;
	assign mod_req.divisor  = cnt_q[top_lvl];

	mrq_mem u_mem (
		.clk   (clk),
		.wr    (mem_wr),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	mrq_mod u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mod_req),
		.rsp    (mod_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			lvl_q      <= '0;
			idx_q      <= '0;
			sel_slot_q <= '0;
			id_q       <= '0;
			for (int lv = 0; lv < LEVELS; lv++) begin
				cnt_q[lv] <= '0;
			end
			total_q    <= '0;
			mode_q     <= MODE_RST;
			max_q      <= MAX_TOTAL_RST;
			done_q     <= 1'b0;
			success_q  <= 1'b0;
			found_q    <= 1'b0;
			sel_id_q   <= '0;
		end else begin
			done_q <= 1'b0;

			if (cfg_we) begin
				case (cfg_index)
					REG_MODE:      mode_q <= cfg_data[MODE_W-1:0];
					REG_MAX_TOTAL: max_q  <= cfg_data[TOT_W-1:0];
					default:       ;
				endcase
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						// default result word: all zero
						success_q <= 1'b0;
						found_q   <= 1'b0;
						sel_id_q  <= '0;
						case (act)
							ACT_INSERT: begin
								done_q    <= 1'b1;
								success_q <= ins_prio_hi || ins_room;
								if (!ins_prio_hi && ins_room) begin
									cnt_q[ins_lvl] <= cnt_q[ins_lvl] + 1'b1;
									total_q        <= total_q + 1'b1;
								end
							end
							ACT_REMOVE: begin
								lvl_q   <= '0;
								idx_q   <= '0;
								id_q    <= in_id;
								state_q <= S_RM_LVL;
							end
							ACT_SELECT: begin
								if (top_any && sel_mode_ok) begin
									lvl_q      <= top_lvl;
									sel_slot_q <= '0;
									state_q    <= (mode_q == MODE_RANDOM) ? S_SEL_MOD : S_SEL_RD;
								end else begin
									done_q <= 1'b1;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_RM_LVL: begin
					if (idx_q < cnt_q[lvl_q]) begin
						state_q <= S_RM_CMP;
					end else if (lvl_q == LVL_W'(LEVELS - 1)) begin
						// id not held anywhere
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						lvl_q <= lvl_q + 1'b1;
						idx_q <= '0;
					end
				end
				S_RM_CMP: begin
					if (mem_rdata == id_q) begin
						state_q <= S_SH_RD;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_RM_LVL;
					end
				end
				S_SH_RD: begin
					if (CNT_W'(idx_q + 1'b1) < cnt_q[lvl_q]) begin
						state_q <= S_SH_WR;
					end else begin
						// gap reached the tail
						cnt_q[lvl_q] <= cnt_q[lvl_q] - 1'b1;
						if (total_q != '0) begin
							total_q <= total_q - 1'b1;
						end
						done_q    <= 1'b1;
						success_q <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				S_SH_WR: begin
					idx_q   <= idx_q + 1'b1;
					state_q <= S_SH_RD;
				end
				S_SEL_MOD: begin
					if (mod_rsp.done) begin
						sel_slot_q <= mod_rsp.rem[SLOT_W-1:0];
						state_q    <= S_SEL_RD;
					end
				end
				S_SEL_RD: begin
					state_q <= S_SEL_OUT;
				end
				S_SEL_OUT: begin
					done_q    <= 1'b1;
					success_q <= 1'b1;
					found_q   <= 1'b1;
					sel_id_q  <= PID_W'(mem_rdata);
					state_q   <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done        = done_q;
	assign success     = success_q;
	assign found       = found_q;
	assign selected_id = sel_id_q;

	// running total always matches the per-level counters
	`MRQ_ASSERT(a_total_sum, total_q == cnt_sum, "total count differs from level counts")
	// a word with an id must also report success
	`MRQ_ASSERT_IMPLY(a_found_ok, done_q && found_q, success_q, "found without success")
	// no id leaks out of a word without one
	`MRQ_ASSERT_IMPLY(a_no_id, done_q && !found_q, sel_id_q == '0, "stray selected id")
	// every accepted command either finishes at once or holds busy
	`MRQ_ASSERT_NEXT(a_accept, start && !busy, busy || done_q, "accepted command dropped")
endmodule
